// File: rtl/sftdt_pkg.sv
`timescale 1ns / 1ps
package sftdt_pkg;

  // Microcode operations
  typedef enum logic [2:0] {
    OP_WAIT,
    OP_SIGN,
    OP_INT,
    OP_POINT,
    OP_FRAC
  } op_t;

  // One control word: operation, power of ten for integer digits,
  // forced emit (units digit), target step when the operation finishes.
  typedef struct packed {
    op_t        op;
    logic [2:0] pow;
    logic       force_emit;
    logic [3:0] nxt;
  } ucode_t;

  localparam logic [3:0] StepWait  = 4'd0;
  localparam logic [3:0] StepSign  = 4'd1;
  localparam logic [3:0] StepInt4  = 4'd2;
  localparam logic [3:0] StepInt3  = 4'd3;
  localparam logic [3:0] StepInt2  = 4'd4;
  localparam logic [3:0] StepInt1  = 4'd5;
  localparam logic [3:0] StepInt0  = 4'd6;
  localparam logic [3:0] StepPoint = 4'd7;
  localparam logic [3:0] StepFrac  = 4'd8;

  localparam logic [6:0] CharMinus = 7'h2D;
  localparam logic [6:0] CharPoint = 7'h2E;
  localparam logic [6:0] CharZero  = 7'h30;
  localparam logic [6:0] CharNine  = 7'h39;

  localparam logic [3:0]  MaxChars  = 4'd12;
  // 50000 - 0x8000, subtracted before the fifth fraction digit
  localparam logic [20:0] RoundAdj  = 21'd17232;
  localparam logic [2:0]  AdjDigit  = 3'd4;
  localparam logic [3:0]  WrapDigit = 4'd5;

  function automatic ucode_t ucode(input logic [3:0] step);
    ucode_t w;
    unique case (step)
      StepWait:  w = '{OP_WAIT,  3'd0, 1'b0, StepSign};
      StepSign:  w = '{OP_SIGN,  3'd0, 1'b0, StepInt4};
      StepInt4:  w = '{OP_INT,   3'd4, 1'b0, StepInt3};
      StepInt3:  w = '{OP_INT,   3'd3, 1'b0, StepInt2};
      StepInt2:  w = '{OP_INT,   3'd2, 1'b0, StepInt1};
      StepInt1:  w = '{OP_INT,   3'd1, 1'b0, StepInt0};
      StepInt0:  w = '{OP_INT,   3'd0, 1'b1, StepPoint};
      StepPoint: w = '{OP_POINT, 3'd0, 1'b0, StepFrac};
      StepFrac:  w = '{OP_FRAC,  3'd0, 1'b0, StepWait};
      default:   w = '{OP_WAIT,  3'd0, 1'b0, StepWait};
    endcase
    return w;
  endfunction

  // k * 10^p
  function automatic logic [16:0] pow_mult(input logic [2:0] p, input logic [3:0] k);
    logic [16:0] base;
    unique case (p)
      3'd0:    base = 17'd1;
      3'd1:    base = 17'd10;
      3'd2:    base = 17'd100;
      3'd3:    base = 17'd1000;
      3'd4:    base = 17'd10000;
      default: base = 17'd0;
    endcase
    return 17'(base * {13'd0, k});
  endfunction

  // tolerance after fraction digit fd has been emitted
  function automatic logic [19:0] delta_after(input logic [2:0] fd);
    logic [19:0] d;
    unique case (fd)
      3'd0:    d = 20'd100;
      3'd1:    d = 20'd1000;
      3'd2:    d = 20'd10000;
      3'd3:    d = 20'd100000;
      default: d = 20'd1000000;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/scaled_fixed_to_decimal_text_top.sv
`timescale 1ns / 1ps
// Signed 16.16 fixed-point to shortest decimal ASCII text. Each value taken
// on the slave stream leaves as 3 to 12 characters on the master stream,
// one character per transaction, tlast on the final one: an optional '-',
// the integer part without leading zeros, '.', then one to five fraction
// digits (the shortest string that reads back to the same value). A small
// microcode ROM steps a narrow datapath through sign, five integer digit
// positions, point and a fraction loop, one step per clock while the
// output slot is free; stalls on the master side hold the sequencer. A
// new value is taken while the last character still sits in the output
// register.
module scaled_fixed_to_decimal_text_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] fixed_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] text_char, [7] zero
  output logic        m_axis_tlast    // last_char
);
  import sftdt_pkg::*;

  // sequencer and datapath registers
  logic [3:0]  step, step_next;
  logic        neg, neg_next;
  logic        started, started_next;   // an integer digit has been emitted
  logic [15:0] ipart, ipart_next;       // remaining integer part
  logic [19:0] frac, frac_next;         // scaled fraction residue
  logic [2:0]  fd, fd_next;             // fraction digits emitted
  logic [3:0]  cnt, cnt_next;           // characters emitted

  // output register
  logic        out_valid;
  logic [6:0]  out_char;
  logic        out_last;

  ucode_t      uc;
  logic        accept, go, emit, emit_last;
  logic [6:0]  emit_char;
  logic [31:0] mag;
  logic [15:0] low_in;

  // integer digit unit
  logic [3:0]  idig;
  logic [16:0] isub;

  // fraction digit unit
  logic [20:0] ft;
  logic [3:0]  fdig;
  logic [19:0] fs_new;
  logic        fcont;

  assign uc     = ucode(step);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign go     = !out_valid || m_axis_tready;   // output slot free

  assign s_axis_tready = (uc.op == OP_WAIT);

  // magnitude of the incoming value; -2^31 maps to 2^31 unsigned
  assign mag    = s_axis_tdata[31] ? (~s_axis_tdata + 32'd1) : s_axis_tdata;
  assign low_in = mag[15:0];

  // integer digit: parallel compare against k*10^p
  always_comb begin
    idig = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if ({1'b0, ipart} >= pow_mult(uc.pow, 4'(k))) idig = 4'(k);
    end
    isub = {1'b0, ipart} - pow_mult(uc.pow, idig);
  end

  // fraction digit; residue stays below 655360 so the high part is 0..9,
  // except a wrap on the fifth digit, where the adjusted residue goes
  // negative and the digit is forced to 5
  always_comb begin
    ft     = {1'b0, frac} - ((fd == AdjDigit) ? RoundAdj : 21'd0);
    fdig   = ft[20] ? WrapDigit : ft[19:16];
    fs_new = ({4'd0, ft[15:0]} << 3) + ({4'd0, ft[15:0]} << 1);
    fcont  = (fs_new > delta_after(fd)) && ((cnt + 4'd1) < MaxChars);
  end

  // microcode execution
  always_comb begin
    step_next    = step;
    neg_next     = neg;
    started_next = started;
    ipart_next   = ipart;
    frac_next    = frac;
    fd_next      = fd;
    emit         = 1'b0;
    emit_char    = CharZero;
    emit_last    = 1'b0;
    unique case (uc.op)
      OP_WAIT: begin
        if (accept) begin
          neg_next     = s_axis_tdata[31];
          started_next = 1'b0;
          ipart_next   = mag[31:16];
          frac_next    = ({4'd0, low_in} << 3) + ({4'd0, low_in} << 1) + 20'd5;
          fd_next      = 3'd0;
          step_next    = uc.nxt;
        end
      end
      OP_SIGN: begin
        if (go) begin
          emit      = neg;
          emit_char = CharMinus;
          step_next = uc.nxt;
        end
      end
      OP_INT: begin
        if (go) begin
          emit       = (idig != 4'd0) || started || uc.force_emit;
          emit_char  = CharZero + {3'd0, idig};
          ipart_next = isub[15:0];
          if (emit) started_next = 1'b1;
          step_next  = uc.nxt;
        end
      end
      OP_POINT: begin
        if (go) begin
          emit      = 1'b1;
          emit_char = CharPoint;
          step_next = uc.nxt;
        end
      end
      OP_FRAC: begin
        if (go) begin
          emit      = 1'b1;
          emit_char = CharZero + {3'd0, fdig};
          emit_last = !fcont;
          frac_next = fs_new;
          fd_next   = fd + 3'd1;
          step_next = fcont ? step : uc.nxt;   // conditional loop
        end
      end
      default: step_next = StepWait;
    endcase
  end

  assign cnt_next = accept ? 4'd0 : (cnt + {3'd0, emit});

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= StepWait;
      out_valid <= 1'b0;
      started   <= 1'b0;
      cnt       <= 4'd0;
      fd        <= 3'd0;
    end else begin
      step    <= step_next;
      started <= started_next;
      cnt     <= cnt_next;
      fd      <= fd_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    neg   <= neg_next;
    ipart <= ipart_next;
    frac  <= frac_next;
    if (emit) begin
      out_char <= emit_char;
      out_last <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_char};
  assign m_axis_tlast  = out_last;

  // never more than twelve characters per value
  assert property (@(posedge clk) disable iff (rst) cnt <= MaxChars)
    else $error("character count overrun");

  // integer digit positions always see a remainder below ten times the power
  assert property (@(posedge clk) disable iff (rst)
    (uc.op == OP_INT) |-> ({1'b0, ipart} < pow_mult(uc.pow, 4'd10)))
    else $error("integer remainder out of range");

  // the point is only emitted once the integer part has produced a digit
  assert property (@(posedge clk) disable iff (rst)
    (go && uc.op == OP_POINT) |-> started)
    else $error("point without integer digits");

  // the final character of a value is always a fraction digit
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (out_char >= CharZero && out_char <= CharNine))
    else $error("last character is not a digit");

  // an accepted value always starts at the sign step
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (step == StepSign))
    else $error("sequencer did not start after accept");

endmodule
